### rtl/mfd_pkg.sv
package mfd_pkg;

    // Receive buffer size: header + length bytes + body must not exceed this
    localparam logic [29:0] FRAME_BUFFER_BYTES = 30'd1024;

    // Queue between the front and back parts
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Parse phases
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    // Byte roles
    localparam logic [1:0] ROLE_HEADER  = 2'd0;
    localparam logic [1:0] ROLE_LENGTH  = 2'd1;
    localparam logic [1:0] ROLE_BODY    = 2'd2;
    localparam logic [1:0] ROLE_DISCARD = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NONCANON  = 2'd1;
    localparam logic [1:0] ERR_OVERLONG  = 2'd2;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd3;

    localparam logic [1:0] LEN_IDX_LAST = 2'd3;

    // A received byte after classification
    typedef struct packed {
        logic [7:0] data;
        logic       cont;      // continuation bit of a length byte
        logic       low_zero;  // low seven bits are all zero
    } t_cls;

endpackage

### rtl/mqtt_frame_deframer_top.sv
// MQTT frame deframer. Push one byte of the TCP stream per transaction; pop
// one result per byte, in order. Each result tags the byte as fixed header,
// length byte, body byte or discarded, passes the byte through, marks the
// byte that ends a frame (the last body byte, or the final length byte of an
// empty body), gives the decoded remaining length on the final length byte
// and on every body byte, and reports the error code. Errors (non-canonical
// zero final length byte, length over four bytes, frame larger than the
// 1024-byte receive buffer) are sticky until reset; every later byte comes
// back as discarded. Throughput is one byte per clock while pop keeps the
// output drained: the length decode is a 28-bit add and a 30-bit size
// compare in the back part. Each byte passes through the front register,
// then a queue entry, then the output register. A four-entry queue sits
// between the front and back parts, so the input keeps taking bytes while
// pop is held low, until the queue and the front register are full.
module mqtt_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte transaction
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    // result transaction
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_byte_role,
    output logic [7:0]  o_data_byte,
    output logic        o_frame_end,
    output logic [27:0] o_body_length,
    output logic [1:0]  o_error_code
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    mfd_pkg::t_cls q_in_item;
    mfd_pkg::t_cls q_out_item;

    // Front: take the byte and classify its length-byte bits
    mfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_rx_byte (i_rx_byte),
        .o_full    (full),
        .o_q_push  (q_push),
        .o_q_item  (q_in_item),
        .i_q_full  (q_full)
    );

    // Decouple the two sides
    mfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out_item),
        .o_empty (q_empty)
    );

    // Back: run the parse state and hold the result for the consumer
    mfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (q_out_item),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_byte_role   (o_byte_role),
        .o_data_byte   (o_data_byte),
        .o_frame_end   (o_frame_end),
        .o_body_length (o_body_length),
        .o_error_code  (o_error_code)
    );

endmodule

### rtl/mfd_front.sv
module mfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_rx_byte,
    output logic          o_full,
    output logic          o_q_push,
    output mfd_pkg::t_cls o_q_item,
    input  logic          i_q_full
);

    logic          r_valid;
    logic          n_valid;
    mfd_pkg::t_cls r_item;
    logic          accept;

    // Hold the byte only while the queue refuses it
    assign o_full   = r_valid && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_item = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_q_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data     <= i_rx_byte;
            r_item.cont     <= i_rx_byte[7];
            r_item.low_zero <= (i_rx_byte[6:0] == 7'd0);
        end
    end

endmodule

### rtl/mfd_queue.sv
module mfd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mfd_pkg::t_cls i_item,
    output logic          o_full,
    input  logic          i_pop,
    output mfd_pkg::t_cls o_item,
    output logic          o_empty
);

    mfd_pkg::t_cls                  r_mem [mfd_pkg::QUEUE_DEPTH];
    logic [mfd_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [mfd_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [mfd_pkg::QUEUE_AW:0]     r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == (mfd_pkg::QUEUE_AW+1)'(mfd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/mfd_back.sv
module mfd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mfd_pkg::t_cls i_item,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [1:0]    o_byte_role,
    output logic [7:0]    o_data_byte,
    output logic          o_frame_end,
    output logic [27:0]   o_body_length,
    output logic [1:0]    o_error_code
);

    logic [1:0]  r_phase,   n_phase;
    logic [27:0] r_acc,     n_acc;
    logic [1:0]  r_idx,     n_idx;
    logic [27:0] r_left,    n_left;
    logic [1:0]  r_err,     n_err;

    logic        r_out_valid;
    logic [1:0]  r_role,    n_role;
    logic [7:0]  r_data;
    logic        r_fend,    n_fend;
    logic [27:0] r_blen,    n_blen;

    logic [27:0] shifted;
    logic [27:0] acc_sum;
    logic [29:0] total;
    logic [27:0] left_dec;

    // Advance when the output register is free or being emptied
    assign o_q_pop = !i_q_empty && (!r_out_valid || i_pop);
    assign o_empty = !r_out_valid;

    always_comb begin
        case (r_idx)
            2'd0:    shifted = {21'd0, i_item.data[6:0]};
            2'd1:    shifted = {14'd0, i_item.data[6:0], 7'd0};
            2'd2:    shifted = {7'd0, i_item.data[6:0], 14'd0};
            default: shifted = {i_item.data[6:0], 21'd0};
        endcase
    end

    assign acc_sum  = r_acc + shifted;
    assign total    = {2'b00, acc_sum} + {28'd0, r_idx} + 30'd2;
    assign left_dec = r_left - 28'd1;

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_idx   = r_idx;
        n_left  = r_left;
        n_err   = r_err;
        n_role  = mfd_pkg::ROLE_HEADER;
        n_fend  = 1'b0;
        n_blen  = 28'd0;
        if (r_err != mfd_pkg::ERR_NONE) begin
            n_role = mfd_pkg::ROLE_DISCARD;
        end else begin
            case (r_phase)
                mfd_pkg::PH_LENGTH: begin
                    n_role = mfd_pkg::ROLE_LENGTH;
                    n_acc  = acc_sum;
                    if (!i_item.cont) begin
                        if ((r_idx != 2'd0) && i_item.low_zero) begin
                            n_err = mfd_pkg::ERR_NONCANON;
                        end else if (total > mfd_pkg::FRAME_BUFFER_BYTES) begin
                            n_err = mfd_pkg::ERR_TOO_LARGE;
                        end else begin
                            n_blen = acc_sum;
                            if (acc_sum == 28'd0) begin
                                n_fend  = 1'b1;
                                n_phase = mfd_pkg::PH_HEADER;
                            end else begin
                                n_left  = acc_sum;
                                n_phase = mfd_pkg::PH_BODY;
                            end
                        end
                    end else if (r_idx == mfd_pkg::LEN_IDX_LAST) begin
                        n_err = mfd_pkg::ERR_OVERLONG;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
                mfd_pkg::PH_BODY: begin
                    n_role = mfd_pkg::ROLE_BODY;
                    n_blen = r_acc;
                    n_left = left_dec;
                    if (left_dec == 28'd0) begin
                        n_fend  = 1'b1;
                        n_phase = mfd_pkg::PH_HEADER;
                    end
                end
                default: begin
                    // header, and the unused phase code behaves the same
                    n_role  = mfd_pkg::ROLE_HEADER;
                    n_phase = mfd_pkg::PH_LENGTH;
                    n_acc   = 28'd0;
                    n_idx   = 2'd0;
                    n_left  = 28'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mfd_pkg::PH_HEADER;
            r_acc       <= 28'd0;
            r_idx       <= 2'd0;
            r_left      <= 28'd0;
            r_err       <= mfd_pkg::ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_idx       <= n_idx;
                r_left      <= n_left;
                r_err       <= n_err;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_role <= n_role;
            r_data <= i_item.data;
            r_fend <= n_fend;
            r_blen <= n_blen;
        end
    end

    assign o_byte_role   = r_role;
    assign o_data_byte   = r_data;
    assign o_frame_end   = r_fend;
    assign o_body_length = r_blen;
    assign o_error_code  = r_err;

endmodule
